@@ hw/rtl/pme_pkg.sv @@
// Shared types and constants of the polygon metrics engine.
// Used by every module of the block. It depends on nothing else.
package pme_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int ADDR_W  = $clog2(MAX_VERTICES);
    localparam int COUNT_W = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W   = 16 + ADDR_W + 1;
    localparam int AREA_W  = 41;
    localparam int CROSS_W = 33;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [31:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic                     overflow;
        logic signed [AREA_W-1:0] area;
        logic signed [SUM_W-1:0]  sum_x;
        logic signed [SUM_W-1:0]  sum_y;
        logic signed [15:0]       min_x;
        logic signed [15:0]       min_y;
        logic signed [15:0]       max_x;
        logic signed [15:0]       max_y;
    } job_t;

endpackage

@@ hw/rtl/pme_front.sv @@
// Front part: accepts vertex beats, writes the vertex store and keeps the
// running shoelace sum, coordinate sums and box. Depends on pme_pkg.
module pme_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [15:0]      vertex_x,
    input  logic signed [15:0]      vertex_y,
    input  logic                    last,
    input  logic                    store_busy,
    input  logic                    q_full,
    output logic                    q_push,
    output pme_pkg::job_t           q_job,
    output pme_pkg::store_wr_t      store_wr
);

    localparam logic [1:0] S_ACC  = 2'd0;
    localparam logic [1:0] S_FIN1 = 2'd1;
    localparam logic [1:0] S_FIN2 = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [pme_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [31:0] first_reg, first_next, prev_reg, prev_next;
    logic signed [pme_pkg::AREA_W-1:0] area_reg, area_next;
    logic signed [pme_pkg::CROSS_W-1:0] cross_reg, cross_next;
    logic cross_v_reg, cross_v_next;
    logic signed [pme_pkg::SUM_W-1:0] sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic signed [15:0] minx_reg, minx_next, miny_reg, miny_next;
    logic signed [15:0] maxx_reg, maxx_next, maxy_reg, maxy_next;
    logic ovf_reg, ovf_next;

    logic accept;
    logic signed [15:0] ax, ay, bx, by;
    logic signed [31:0] prod1, prod2;

    assign in_stall = (state_reg != S_ACC) || store_busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        // The cross operands are the previous vertex and either the new beat
        // or, when closing the polygon, the first vertex.
        ax = prev_reg[15:0];
        ay = prev_reg[31:16];
        if (state_reg == S_FIN1)
        begin
            bx = first_reg[15:0];
            by = first_reg[31:16];
        end
        else
        begin
            bx = vertex_x;
            by = vertex_y;
        end
        prod1 = ax * by;
        prod2 = ay * bx;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        first_next   = first_reg;
        prev_next    = prev_reg;
        cross_next   = cross_reg;
        cross_v_next = 1'b0;
        sumx_next    = sumx_reg;
        sumy_next    = sumy_reg;
        minx_next    = minx_reg;
        miny_next    = miny_reg;
        maxx_next    = maxx_reg;
        maxy_next    = maxy_reg;
        ovf_next     = ovf_reg;
        q_push       = 1'b0;
        store_wr.we   = 1'b0;
        store_wr.addr = count_reg[pme_pkg::ADDR_W-1:0];
        store_wr.data = {vertex_y, vertex_x};
        area_next = area_reg;
        if (cross_v_reg)
        begin
            area_next = area_reg + pme_pkg::AREA_W'(cross_reg);
        end

        unique case (state_reg)
            S_ACC:
            begin
                if (accept)
                begin
                    if (count_reg < pme_pkg::COUNT_W'(pme_pkg::MAX_VERTICES))
                    begin
                        store_wr.we = 1'b1;
                        if (count_reg == '0)
                        begin
                            first_next = {vertex_y, vertex_x};
                            minx_next = vertex_x;
                            maxx_next = vertex_x;
                            miny_next = vertex_y;
                            maxy_next = vertex_y;
                        end
                        else
                        begin
                            cross_next = pme_pkg::CROSS_W'(prod1) -
                                         pme_pkg::CROSS_W'(prod2);
                            cross_v_next = 1'b1;
                            if (vertex_x < minx_reg) minx_next = vertex_x;
                            if (vertex_x > maxx_reg) maxx_next = vertex_x;
                            if (vertex_y < miny_reg) miny_next = vertex_y;
                            if (vertex_y > maxy_reg) maxy_next = vertex_y;
                        end
                        sumx_next  = sumx_reg + pme_pkg::SUM_W'(vertex_x);
                        sumy_next  = sumy_reg + pme_pkg::SUM_W'(vertex_y);
                        prev_next  = {vertex_y, vertex_x};
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = S_FIN1;
                    end
                end
            end
            S_FIN1:
            begin
                cross_next   = pme_pkg::CROSS_W'(prod1) - pme_pkg::CROSS_W'(prod2);
                cross_v_next = 1'b1;
                state_next   = S_FIN2;
            end
            S_FIN2:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = S_ACC;
                    count_next = '0;
                    first_next = '0;
                    prev_next  = '0;
                    area_next  = '0;
                    sumx_next  = '0;
                    sumy_next  = '0;
                    minx_next  = '0;
                    miny_next  = '0;
                    maxx_next  = '0;
                    maxy_next  = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_comb
    begin
        q_job.count    = count_reg;
        q_job.overflow = ovf_reg;
        q_job.area     = area_reg;
        q_job.sum_x    = sumx_reg;
        q_job.sum_y    = sumy_reg;
        q_job.min_x    = minx_reg;
        q_job.min_y    = miny_reg;
        q_job.max_x    = maxx_reg;
        q_job.max_y    = maxy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_ACC;
            count_reg   <= '0;
            first_reg   <= '0;
            prev_reg    <= '0;
            area_reg    <= '0;
            cross_v_reg <= 1'b0;
            sumx_reg    <= '0;
            sumy_reg    <= '0;
            minx_reg    <= '0;
            miny_reg    <= '0;
            maxx_reg    <= '0;
            maxy_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            prev_reg    <= prev_next;
            area_reg    <= area_next;
            cross_v_reg <= cross_v_next;
            sumx_reg    <= sumx_next;
            sumy_reg    <= sumy_next;
            minx_reg    <= minx_next;
            miny_reg    <= miny_next;
            maxx_reg    <= maxx_next;
            maxy_reg    <= maxy_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cross_reg <= cross_next;
    end

endmodule

@@ hw/rtl/pme_queue.sv @@
// Short job queue between the front and back parts.
// Holds finished polygon summaries. Depends on pme_pkg.
module pme_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pme_pkg::job_t push_job,
    input  logic          pop,
    output pme_pkg::job_t pop_job,
    output logic          full,
    output logic          empty
);

    pme_pkg::job_t slot_reg [pme_pkg::QDEPTH];
    logic [pme_pkg::QPTR_W-1:0] wp_reg, rp_reg;
    logic [pme_pkg::QPTR_W:0]   cnt_reg;

    assign full    = (cnt_reg == (pme_pkg::QPTR_W + 1)'(pme_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= (wp_reg == pme_pkg::QPTR_W'(pme_pkg::QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rp_reg <= (rp_reg == pme_pkg::QPTR_W'(pme_pkg::QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (pme_pkg::QPTR_W + 1)'(push && !full)
                               - (pme_pkg::QPTR_W + 1)'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= push_job;
        end
    end

endmodule

@@ hw/rtl/pme_back.sv @@
// Back part: holds the vertex store, divides the sums for the centroid,
// runs the radius pass over the store and drives the result. Depends on pme_pkg.
module pme_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pme_pkg::store_wr_t   store_wr,
    input  logic                 q_empty,
    input  pme_pkg::job_t        q_job,
    output logic                 q_pop,
    output logic                 store_busy,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic signed [40:0]   twice_area,
    output logic signed [15:0]   centroid_x,
    output logic signed [15:0]   centroid_y,
    output logic signed [15:0]   box_center_x,
    output logic signed [15:0]   box_center_y,
    output logic [14:0]          box_half_w,
    output logic [14:0]          box_half_h,
    output logic [32:0]          radius_sq,
    output logic [8:0]           vertex_count
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DIV  = 3'd1;
    localparam logic [2:0] B_RAD  = 3'd2;
    localparam logic [2:0] B_FIN  = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;
    localparam int STEP_W = $clog2(pme_pkg::SUM_W);
    localparam int REM_W  = pme_pkg::COUNT_W + 1;

    logic [31:0] mem [pme_pkg::MAX_VERTICES];
    logic [31:0] rd_data_reg;
    logic [pme_pkg::ADDR_W-1:0] rd_addr;
    logic rd_en;

    logic [2:0] state_reg, state_next;
    pme_pkg::job_t job_reg, job_next;
    logic sel_reg, sel_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [pme_pkg::SUM_W-1:0] mag_reg, mag_next, quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next, trial;
    logic neg_reg, neg_next;
    logic signed [15:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [pme_pkg::COUNT_W-1:0] idx_reg, idx_next;
    logic p1_v_reg, p2_v_reg;
    logic [33:0] sqx_reg, sqy_reg, rmax_reg, rmax_next, dsum;
    logic signed [16:0] dx, dy;
    logic signed [33:0] sqx_s, sqy_s;
    logic out_valid_reg, out_valid_next;
    logic [pme_pkg::SUM_W-1:0] quo_fin;
    logic signed [16:0] bsx, bsy, bcx, bcy, hw, hh;

    logic [1:0] status_reg;
    logic signed [40:0] area_o_reg;
    logic signed [15:0] cx_o_reg, cy_o_reg, bcx_o_reg, bcy_o_reg;
    logic [14:0] hw_o_reg, hh_o_reg;
    logic [32:0] r_o_reg;
    logic [8:0] n_o_reg;

    assign store_busy = !q_empty || (state_reg == B_DIV) || (state_reg == B_RAD)
                        || (state_reg == B_FIN);
    assign out_valid  = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (store_wr.we)
        begin
            mem[store_wr.addr] <= store_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        trial   = {rem_reg[REM_W-2:0], mag_reg[pme_pkg::SUM_W-1]};
        quo_fin = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
        dx = 17'(signed'(rd_data_reg[15:0])) - 17'(cx_reg);
        dy = 17'(signed'(rd_data_reg[31:16])) - 17'(cy_reg);
        sqx_s = dx * dx;
        sqy_s = dy * dy;
        dsum  = sqx_reg + sqy_reg;
        bsx = 17'(job_reg.min_x) + 17'(job_reg.max_x);
        bsy = 17'(job_reg.min_y) + 17'(job_reg.max_y);
        bcx = bsx >>> 1;
        bcy = bsy >>> 1;
        hw  = bcx - 17'(job_reg.min_x);
        hh  = bcy - 17'(job_reg.min_y);
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        sel_next       = sel_reg;
        step_next      = step_reg;
        mag_next       = mag_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        idx_next       = idx_reg;
        rmax_next      = rmax_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[pme_pkg::ADDR_W-1:0];

        if (p2_v_reg && (dsum > rmax_reg))
        begin
            rmax_next = dsum;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    job_next  = q_job;
                    sel_next  = 1'b0;
                    step_next = '0;
                    rem_next  = '0;
                    quo_next  = '0;
                    neg_next  = q_job.sum_x[pme_pkg::SUM_W-1];
                    mag_next  = q_job.sum_x[pme_pkg::SUM_W-1] ? (~q_job.sum_x + 1'b1)
                                                              : q_job.sum_x;
                    cx_next   = '0;
                    cy_next   = '0;
                    idx_next  = '0;
                    rmax_next = '0;
                    state_next = (q_job.count == '0) ? B_FIN : B_DIV;
                end
            end
            B_DIV:
            begin
                // One restoring step per cycle on the magnitude of the sum.
                if (trial >= {1'b0, job_reg.count})
                begin
                    rem_next = trial - {1'b0, job_reg.count};
                    quo_next = {quo_reg[pme_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[pme_pkg::SUM_W-2:0], 1'b0};
                end
                mag_next  = {mag_reg[pme_pkg::SUM_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(pme_pkg::SUM_W))
                begin
                    // The extra step only collects the finished quotient.
                    quo_next = quo_reg;
                    rem_next = rem_reg;
                    if (!sel_reg)
                    begin
                        cx_next   = quo_fin[15:0];
                        sel_next  = 1'b1;
                        step_next = '0;
                        rem_next  = '0;
                        quo_next  = '0;
                        neg_next  = job_reg.sum_y[pme_pkg::SUM_W-1];
                        mag_next  = job_reg.sum_y[pme_pkg::SUM_W-1]
                                    ? (~job_reg.sum_y + 1'b1) : job_reg.sum_y;
                    end
                    else
                    begin
                        cy_next    = quo_fin[15:0];
                        state_next = B_RAD;
                    end
                end
            end
            B_RAD:
            begin
                if (idx_reg < job_reg.count)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else if (!p1_v_reg && !p2_v_reg)
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                out_valid_next = 1'b1;
                state_next     = B_OUT;
            end
            B_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_v_reg      <= rd_en;
            p2_v_reg      <= p1_v_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        sel_reg  <= sel_next;
        step_reg <= step_next;
        mag_reg  <= mag_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        idx_reg  <= idx_next;
        rmax_reg <= rmax_next;
        sqx_reg  <= 34'(sqx_s);
        sqy_reg  <= 34'(sqy_s);
        if (state_reg == B_FIN)
        begin
            if (job_reg.count < pme_pkg::COUNT_W'(3))
                status_reg <= pme_pkg::ST_FEW;
            else if (job_reg.overflow)
                status_reg <= pme_pkg::ST_DROP;
            else
                status_reg <= pme_pkg::ST_OK;
            area_o_reg <= job_reg.area;
            cx_o_reg   <= cx_reg;
            cy_o_reg   <= cy_reg;
            bcx_o_reg  <= bcx[15:0];
            bcy_o_reg  <= bcy[15:0];
            hw_o_reg   <= hw[14:0];
            hh_o_reg   <= hh[14:0];
            r_o_reg    <= rmax_reg[32:0];
            n_o_reg    <= 9'(job_reg.count);
        end
    end

    assign status       = status_reg;
    assign twice_area   = area_o_reg;
    assign centroid_x   = cx_o_reg;
    assign centroid_y   = cy_o_reg;
    assign box_center_x = bcx_o_reg;
    assign box_center_y = bcy_o_reg;
    assign box_half_w   = hw_o_reg;
    assign box_half_h   = hh_o_reg;
    assign radius_sq    = r_o_reg;
    assign vertex_count = n_o_reg;

endmodule

@@ hw/rtl/polygon_metrics_engine_unit.sv @@
// Top level of the polygon metrics engine.
// Instantiates pme_front, pme_queue and pme_back; depends on pme_pkg.
//
// Usage. Vertices arrive one beat each on the input channel (vertex_x,
// vertex_y in signed Q8.8, last marking the final vertex). A beat is taken
// when in_valid is high and in_stall is low. Within a polygon one beat is
// taken every cycle while store_busy stays low. After the last
// beat the front closes the shoelace sum in S_FIN1 and S_FIN2, then in
// S_PUSH hands a summary to a two-entry queue. The back part then divides
// both coordinate sums (one quotient bit a cycle), runs the radius pass
// over the stored vertices through the single read port of the store and
// a two-stage square pipeline, and presents one result beat. The front
// takes no vertex of the next polygon while the queue holds a summary or
// the back divides, reads the store or loads the result; once the result
// is only waiting to be taken and the queue is empty, the next polygon
// streams in. A stalled result holds steady until out_stall drops. Reset
// clears the state machines, queue pointers and running sums; the store
// needs no clearing, as only entries written for the current polygon are read.
module polygon_metrics_engine_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  vertex_x,
    input  logic signed [15:0]  vertex_y,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic signed [40:0]  twice_area,
    output logic signed [15:0]  centroid_x,
    output logic signed [15:0]  centroid_y,
    output logic signed [15:0]  box_center_x,
    output logic signed [15:0]  box_center_y,
    output logic [14:0]         box_half_w,
    output logic [14:0]         box_half_h,
    output logic [32:0]         radius_sq,
    output logic [8:0]          vertex_count
);

    pme_pkg::store_wr_t store_wr;
    pme_pkg::job_t      push_job, pop_job;
    logic q_push, q_pop, q_full, q_empty, store_busy;

    // Front: takes vertex beats and keeps the running polygon sums.
    pme_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .vertex_x   (vertex_x),
        .vertex_y   (vertex_y),
        .last       (last),
        .store_busy (store_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job),
        .store_wr   (store_wr)
    );

    // Queue of finished polygon summaries.
    pme_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: centroid division, radius pass and the result register.
    pme_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .store_wr     (store_wr),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .q_pop        (q_pop),
        .store_busy   (store_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .twice_area   (twice_area),
        .centroid_x   (centroid_x),
        .centroid_y   (centroid_y),
        .box_center_x (box_center_x),
        .box_center_y (box_center_y),
        .box_half_w   (box_half_w),
        .box_half_h   (box_half_h),
        .radius_sq    (radius_sq),
        .vertex_count (vertex_count)
    );

endmodule

@@ hw/rtl/pme_checker.sv @@
// Port-level checks for the polygon metrics engine, bound to the top level.
// Depends on pme_pkg and polygon_metrics_engine_unit.
module pme_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic signed [40:0] twice_area,
    input logic [32:0]        radius_sq,
    input logic [8:0]         vertex_count
);

    // A held result must not change while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(twice_area)
                                   && $stable(radius_sq) && $stable(status))
        else $error("result changed while stalled");

    a_few: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == pme_pkg::ST_FEW) == (vertex_count < 9'd3)))
        else $error("status does not match vertex count");

    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (vertex_count < 9'd3) |-> twice_area == '0)
        else $error("degenerate polygon with nonzero area");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vertex_count <= 9'(pme_pkg::MAX_VERTICES))
        else $error("vertex count above capacity");

endmodule

bind polygon_metrics_engine_unit pme_checker u_pme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .twice_area   (twice_area),
    .radius_sq    (radius_sq),
    .vertex_count (vertex_count)
);
